[hw/rtl/gpw_pkg.sv]
// Shared types and constants for the glyph pixel writer.
package gpw_pkg;

  localparam int ADDR_W   = 32;
  localparam int COLOR_W  = 32;
  localparam int COORD_W  = 12;
  localparam int DIM_W    = 13;
  localparam int PITCH_W  = 16;
  localparam int PSIZE_W  = 2;
  localparam int NBYTES_W = 3;
  localparam int BYTE_W   = 8;
  localparam int CODE_W   = 8;
  localparam int GROW_W   = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FB_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SIZE = 3'd4;

  localparam logic [ADDR_W-1:0]  FB_BASE_RST    = 32'd0;
  localparam logic [DIM_W-1:0]   FB_WIDTH_RST   = 13'd640;
  localparam logic [DIM_W-1:0]   FB_HEIGHT_RST  = 13'd480;
  localparam logic [PITCH_W-1:0] ROW_PITCH_RST  = 16'd2560;
  localparam logic [PSIZE_W-1:0] PIXEL_SIZE_RST = 2'd3;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LOAD_Y,
    CMD_LOAD_X,
    CMD_MUL_STEP,
    CMD_SAVE_ROW,
    CMD_NEXT_COL,
    CMD_NEXT_ROW
  } alu_cmd_t;

endpackage

[hw/rtl/gpw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gpw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/gpw_alu.sv]
// Shared address adder with shift-add multiply and row/column stepping.
module gpw_alu (
  input  logic                              clk,
  input  gpw_pkg::alu_cmd_t                 cmd,
  input  logic [gpw_pkg::ADDR_W-1:0]        base,
  input  logic [gpw_pkg::PITCH_W-1:0]       pitch,
  input  logic [gpw_pkg::NBYTES_W-1:0]      nbytes,
  input  logic [gpw_pkg::COORD_W-1:0]       py,
  input  logic [gpw_pkg::COORD_W-1:0]       px,
  output logic [gpw_pkg::ADDR_W-1:0]        addr
);

  logic [gpw_pkg::ADDR_W-1:0]  acc;
  logic [gpw_pkg::ADDR_W-1:0]  row_start;
  logic [gpw_pkg::ADDR_W-1:0]  mcand;
  logic [gpw_pkg::COORD_W-1:0] mplier;
  logic [gpw_pkg::ADDR_W-1:0]  op_a;
  logic [gpw_pkg::ADDR_W-1:0]  op_b;
  logic [gpw_pkg::ADDR_W-1:0]  sum;

  always_comb begin
    op_a = acc;
    op_b = '0;
    case (cmd)
      gpw_pkg::CMD_MUL_STEP: op_b = mplier[0] ? mcand : '0;
      gpw_pkg::CMD_NEXT_COL: op_b = gpw_pkg::ADDR_W'(nbytes);
      gpw_pkg::CMD_NEXT_ROW: begin
        op_a = row_start;
        op_b = gpw_pkg::ADDR_W'(pitch);
      end
      default: op_b = '0;
    endcase
  end

  assign sum  = op_a + op_b;
  assign addr = acc;

  always_ff @(posedge clk) begin
    case (cmd)
      gpw_pkg::CMD_LOAD_Y: begin
        acc    <= base;
        mcand  <= gpw_pkg::ADDR_W'(pitch);
        mplier <= py;
      end
      gpw_pkg::CMD_LOAD_X: begin
        mcand  <= gpw_pkg::ADDR_W'(px);
        mplier <= gpw_pkg::COORD_W'(nbytes);
      end
      gpw_pkg::CMD_MUL_STEP: begin
        acc    <= sum;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
      end
      gpw_pkg::CMD_SAVE_ROW: row_start <= acc;
      gpw_pkg::CMD_NEXT_COL: acc <= sum;
      gpw_pkg::CMD_NEXT_ROW: begin
        acc       <= sum;
        row_start <= sum;
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/bitmap_glyph_pixel_writer.sv]
// Top level: glyph store, request sequencer, config registers and pixel output register.
// A load request is accepted in S_IDLE and writes one glyph row byte in S_LOAD. A draw
// request runs its setup steps (accept, 12 shift-add steps of pos_y times row_pitch, 1 operand
// load, 3 shift-add steps of pos_x times bytes per pixel, 1 row-start save) and then
// emits GLYPH_ROWS*GLYPH_COLS pixel writes, one per cycle while the output is taken.
// All address arithmetic goes through one shared 32-bit adder; each pixel adds the bytes
// per pixel (pixel_size plus one) to the running address and each new row adds row_pitch
// to the saved row start. The glyph store is a RAM with one read per glyph row; entries
// never loaded read as undefined. Configuration writes are always accepted and must only
// be issued while no draw is in progress.
module bitmap_glyph_pixel_writer #(
  parameter int GLYPH_ROWS   = 8,
  parameter int GLYPH_COLS   = 8,
  parameter int CHARSET_SIZE = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gpw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic [gpw_pkg::CODE_W-1:0]          char_code,
  input  logic [gpw_pkg::GROW_W-1:0]          glyph_row,
  input  logic [gpw_pkg::BYTE_W-1:0]          row_bits,
  input  logic [gpw_pkg::COORD_W-1:0]         pos_x,
  input  logic [gpw_pkg::COORD_W-1:0]         pos_y,
  input  logic [gpw_pkg::COLOR_W-1:0]         fg_color,
  input  logic [gpw_pkg::COLOR_W-1:0]         bg_color,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gpw_pkg::ADDR_W-1:0]          pixel_addr,
  output logic [gpw_pkg::COLOR_W-1:0]         pixel_data,
  output logic [gpw_pkg::NBYTES_W-1:0]        byte_count,
  output logic                                write_enable,
  output logic                                last
);

  localparam int DEPTH = CHARSET_SIZE * GLYPH_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CCW   = $clog2(CHARSET_SIZE);
  localparam int RW    = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int CW    = (GLYPH_COLS > 1) ? $clog2(GLYPH_COLS) : 1;
  localparam int STEP_W = $clog2(gpw_pkg::COORD_W);
  localparam logic [STEP_W-1:0] Y_LAST = STEP_W'(gpw_pkg::COORD_W - 1);
  localparam logic [STEP_W-1:0] X_LAST = STEP_W'(gpw_pkg::NBYTES_W - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(GLYPH_ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(GLYPH_COLS - 1);
  localparam logic [2:0] MSB_IDX = 3'(gpw_pkg::BYTE_W - 1);
  localparam logic [15:0] CS = 16'(CHARSET_SIZE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL_Y,
    S_LOAD_X,
    S_MUL_X,
    S_ROW0,
    S_EMIT
  } state_t;

  state_t state;

  logic [gpw_pkg::ADDR_W-1:0]   fb_base;
  logic [gpw_pkg::DIM_W-1:0]    fb_width;
  logic [gpw_pkg::DIM_W-1:0]    fb_height;
  logic [gpw_pkg::PITCH_W-1:0]  row_pitch;
  logic [gpw_pkg::PSIZE_W-1:0]  pixel_size;

  logic [CCW-1:0]               ch_q;
  logic [gpw_pkg::GROW_W-1:0]   grow_q;
  logic [gpw_pkg::BYTE_W-1:0]   bits_q;
  logic [gpw_pkg::COORD_W-1:0]  px_q;
  logic [gpw_pkg::COORD_W-1:0]  py_q;
  logic [gpw_pkg::COLOR_W-1:0]  fg_q;
  logic [gpw_pkg::COLOR_W-1:0]  bg_q;
  logic [STEP_W-1:0]            step;
  logic [RW-1:0]                row;
  logic [CW-1:0]                col;
  logic [gpw_pkg::DIM_W-1:0]    x_q;
  logic [gpw_pkg::DIM_W-1:0]    y_q;

  logic [15:0]                  rem;
  logic [CCW-1:0]               ch_mod;
  logic [AW-1:0]                gbase;
  logic [RW-1:0]                rd_row;
  logic                         grow_ok;
  logic                         fire;
  logic                         row_end;
  logic                         row_last;
  logic                         pix_on;
  logic [gpw_pkg::NBYTES_W-1:0] nbytes;
  logic [gpw_pkg::ADDR_W-1:0]   alu_addr;
  gpw_pkg::alu_cmd_t            alu_cmd;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [gpw_pkg::BYTE_W-1:0]   ram_rdata;

  always_comb begin
    rem = 16'(char_code);
    for (int k = 7; k >= 0; k--) begin
      if (rem >= (CS << k)) begin
        rem = rem - (CS << k);
      end
    end
    ch_mod = CCW'(rem);
  end

  assign gbase    = AW'(int'(ch_q) * GLYPH_ROWS);
  assign grow_ok  = int'(grow_q) < GLYPH_ROWS;
  assign nbytes   = gpw_pkg::NBYTES_W'(pixel_size) + 3'd1;
  assign fire     = (state == S_EMIT) && (!out_valid || out_ready);
  assign row_end  = (col == COL_LAST);
  assign row_last = (row == ROW_LAST);
  assign pix_on   = ram_rdata[MSB_IDX - 3'(col)];
  assign rd_row   = (state == S_ROW0) ? '0 : RW'(row + 1'b1);

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign ram_we    = (state == S_LOAD) && grow_ok;
  assign ram_waddr = gbase + AW'(grow_q);
  assign ram_re    = (state == S_ROW0) || (fire && row_end && !row_last);
  assign ram_raddr = gbase + AW'(rd_row);

  always_comb begin
    case (state)
      S_IDLE:   alu_cmd = (in_valid && req_type == gpw_pkg::REQ_DRAW) ?
                          gpw_pkg::CMD_LOAD_Y : gpw_pkg::CMD_NOP;
      S_MUL_Y:  alu_cmd = gpw_pkg::CMD_MUL_STEP;
      S_LOAD_X: alu_cmd = gpw_pkg::CMD_LOAD_X;
      S_MUL_X:  alu_cmd = gpw_pkg::CMD_MUL_STEP;
      S_ROW0:   alu_cmd = gpw_pkg::CMD_SAVE_ROW;
      S_EMIT: begin
        if (!fire) begin
          alu_cmd = gpw_pkg::CMD_NOP;
        end else if (row_end) begin
          alu_cmd = gpw_pkg::CMD_NEXT_ROW;
        end else begin
          alu_cmd = gpw_pkg::CMD_NEXT_COL;
        end
      end
      default:  alu_cmd = gpw_pkg::CMD_NOP;
    endcase
  end

  gpw_alu u_alu (
    .clk    (clk),
    .cmd    (alu_cmd),
    .base   (fb_base),
    .pitch  (row_pitch),
    .nbytes (nbytes),
    .py     (pos_y),
    .px     (px_q),
    .addr   (alu_addr)
  );

  gpw_ram #(
    .WIDTH (gpw_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (bits_q),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_base    <= gpw_pkg::FB_BASE_RST;
      fb_width   <= gpw_pkg::FB_WIDTH_RST;
      fb_height  <= gpw_pkg::FB_HEIGHT_RST;
      row_pitch  <= gpw_pkg::ROW_PITCH_RST;
      pixel_size <= gpw_pkg::PIXEL_SIZE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        gpw_pkg::REG_FB_BASE:    fb_base    <= cfg_data;
        gpw_pkg::REG_FB_WIDTH:   fb_width   <= cfg_data[gpw_pkg::DIM_W-1:0];
        gpw_pkg::REG_FB_HEIGHT:  fb_height  <= cfg_data[gpw_pkg::DIM_W-1:0];
        gpw_pkg::REG_ROW_PITCH:  row_pitch  <= cfg_data[gpw_pkg::PITCH_W-1:0];
        gpw_pkg::REG_PIXEL_SIZE: pixel_size <= cfg_data[gpw_pkg::PSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ch_q   <= ch_mod;
            grow_q <= glyph_row;
            bits_q <= row_bits;
            px_q   <= pos_x;
            py_q   <= pos_y;
            fg_q   <= fg_color;
            bg_q   <= bg_color;
            step   <= '0;
            state  <= (req_type == gpw_pkg::REQ_DRAW) ? S_MUL_Y : S_LOAD;
          end
        end
        S_LOAD: state <= S_IDLE;
        S_MUL_Y: begin
          step <= step + 1'b1;
          if (step == Y_LAST) begin
            state <= S_LOAD_X;
          end
        end
        S_LOAD_X: begin
          step  <= '0;
          state <= S_MUL_X;
        end
        S_MUL_X: begin
          step <= step + 1'b1;
          if (step == X_LAST) begin
            state <= S_ROW0;
          end
        end
        S_ROW0: begin
          row   <= '0;
          col   <= '0;
          x_q   <= gpw_pkg::DIM_W'(px_q);
          y_q   <= gpw_pkg::DIM_W'(py_q);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (fire) begin
            pixel_addr   <= alu_addr;
            pixel_data   <= pix_on ? fg_q : bg_q;
            byte_count   <= nbytes;
            write_enable <= (x_q < fb_width) && (y_q < fb_height);
            last         <= row_end && row_last;
            if (row_end) begin
              col <= '0;
              x_q <= gpw_pkg::DIM_W'(px_q);
              row <= RW'(row + 1'b1);
              y_q <= y_q + 1'b1;
              if (row_last) begin
                state <= S_IDLE;
              end
            end else begin
              col <= CW'(col + 1'b1);
              x_q <= x_q + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("output request raised outside pixel emission");

  a_last_ends_draw: assert property (@(posedge clk) disable iff (rst)
    (fire && row_end && row_last) |=> (state == S_IDLE) && out_valid && last)
    else $error("final pixel did not end the draw");

  a_ram_port_excl: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> !ram_we)
    else $error("glyph read and write in the same cycle");

  a_cell_origin: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROW0) |=> (row == '0) && (col == '0) &&
      (x_q == gpw_pkg::DIM_W'(px_q)) && (y_q == gpw_pkg::DIM_W'(py_q)))
    else $error("cell walk did not start at the cell origin");
`endif

endmodule

[dv/bitmap_glyph_pixel_writer_tb.sv]
// Self-checking testbench for the glyph pixel writer: glyph loads, clipped draws, geometry sweeps.
module bitmap_glyph_pixel_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS          = 8;
  localparam int COLS          = 8;
  localparam int CHARS         = 256;
  localparam int STALL_PCT     = 7;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 100;

  typedef struct packed {
    logic [gpw_pkg::ADDR_W-1:0]   addr;
    logic [gpw_pkg::COLOR_W-1:0]  color;
    logic [gpw_pkg::NBYTES_W-1:0] nbytes;
    logic                         we;
    logic                         is_last;
  } pixel_write_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [gpw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                   cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          req_type = gpw_pkg::REQ_LOAD;
  logic [gpw_pkg::CODE_W-1:0]    char_code = '0;
  logic [gpw_pkg::GROW_W-1:0]    glyph_row = '0;
  logic [gpw_pkg::BYTE_W-1:0]    row_bits = '0;
  logic [gpw_pkg::COORD_W-1:0]   pos_x = '0;
  logic [gpw_pkg::COORD_W-1:0]   pos_y = '0;
  logic [gpw_pkg::COLOR_W-1:0]   fg_color = '0;
  logic [gpw_pkg::COLOR_W-1:0]   bg_color = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [gpw_pkg::ADDR_W-1:0]    pixel_addr;
  logic [gpw_pkg::COLOR_W-1:0]   pixel_data;
  logic [gpw_pkg::NBYTES_W-1:0]  byte_count;
  logic                          write_enable;
  logic                          pix_last;

  bitmap_glyph_pixel_writer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .char_code    (char_code),
    .glyph_row    (glyph_row),
    .row_bits     (row_bits),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .fg_color     (fg_color),
    .bg_color     (bg_color),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_addr   (pixel_addr),
    .pixel_data   (pixel_data),
    .byte_count   (byte_count),
    .write_enable (write_enable),
    .last         (pix_last)
  );

  logic [gpw_pkg::ADDR_W-1:0]  geo_base   = gpw_pkg::FB_BASE_RST;
  logic [gpw_pkg::DIM_W-1:0]   geo_width  = gpw_pkg::FB_WIDTH_RST;
  logic [gpw_pkg::DIM_W-1:0]   geo_height = gpw_pkg::FB_HEIGHT_RST;
  logic [gpw_pkg::PITCH_W-1:0] geo_pitch  = gpw_pkg::ROW_PITCH_RST;
  logic [gpw_pkg::PSIZE_W-1:0] geo_psize  = gpw_pkg::PIXEL_SIZE_RST;

  logic [gpw_pkg::BYTE_W-1:0] font_rows [CHARS][ROWS];
  bit                         font_row_set [CHARS][ROWS];
  bit                         font_drawable [CHARS];
  logic [gpw_pkg::CODE_W-1:0] drawable_codes [$];

  pixel_write_t pending_writes [$];
  pixel_write_t want_write;

  int mismatches     = 0;
  int requests_sent  = 0;
  int loads_sent     = 0;
  int draws_sent     = 0;
  int pixels_checked = 0;
  int pixels_clipped = 0;
  int settings_used  = 0;
  bit no_stalls      = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic predict_draw(input logic [gpw_pkg::CODE_W-1:0] code,
                              input logic [gpw_pkg::COORD_W-1:0] px,
                              input logic [gpw_pkg::COORD_W-1:0] py,
                              input logic [gpw_pkg::COLOR_W-1:0] fg,
                              input logic [gpw_pkg::COLOR_W-1:0] bg);
    pixel_write_t w;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] nbytes;
    logic [gpw_pkg::BYTE_W-1:0] bits;
    nbytes = 32'(geo_psize) + 32'd1;
    for (int r = 0; r < ROWS; r++) begin
      bits = font_rows[code][r];
      y = 32'(py) + 32'(r);
      for (int c = 0; c < COLS; c++) begin
        x = 32'(px) + 32'(c);
        w.addr    = geo_base + y * 32'(geo_pitch) + x * nbytes;
        w.color   = bits[gpw_pkg::BYTE_W-1-c] ? fg : bg;
        w.nbytes  = gpw_pkg::NBYTES_W'(nbytes);
        w.we      = (x < 32'(geo_width)) && (y < 32'(geo_height));
        w.is_last = (r == ROWS-1) && (c == COLS-1);
        pending_writes.push_back(w);
      end
    end
  endtask

  task automatic send_request(input logic rtype, input logic [gpw_pkg::CODE_W-1:0] code,
                              input logic [gpw_pkg::GROW_W-1:0] grow,
                              input logic [gpw_pkg::BYTE_W-1:0] bits,
                              input logic [gpw_pkg::COORD_W-1:0] px,
                              input logic [gpw_pkg::COORD_W-1:0] py,
                              input logic [gpw_pkg::COLOR_W-1:0] fg,
                              input logic [gpw_pkg::COLOR_W-1:0] bg);
    bit complete;
    if (!no_stalls && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 90)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= rtype;
    char_code <= code;
    glyph_row <= grow;
    row_bits  <= bits;
    pos_x     <= px;
    pos_y     <= py;
    fg_color  <= fg;
    bg_color  <= bg;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    if (rtype == gpw_pkg::REQ_LOAD) begin
      loads_sent++;
      font_rows[code][grow] = bits;
      font_row_set[code][grow] = 1'b1;
      complete = 1'b1;
      for (int r = 0; r < ROWS; r++) if (!font_row_set[code][r]) complete = 1'b0;
      if (complete && !font_drawable[code]) begin
        font_drawable[code] = 1'b1;
        drawable_codes.push_back(code);
      end
    end else begin
      draws_sent++;
      predict_draw(code, px, py, fg, bg);
    end
  endtask

  task automatic load_row(input logic [gpw_pkg::CODE_W-1:0] code,
                          input logic [gpw_pkg::GROW_W-1:0] grow,
                          input logic [gpw_pkg::BYTE_W-1:0] bits);
    send_request(gpw_pkg::REQ_LOAD, code, grow, bits, gpw_pkg::COORD_W'($urandom),
                 gpw_pkg::COORD_W'($urandom), $urandom, $urandom);
  endtask

  task automatic draw_char(input logic [gpw_pkg::CODE_W-1:0] code,
                           input logic [gpw_pkg::COORD_W-1:0] px,
                           input logic [gpw_pkg::COORD_W-1:0] py,
                           input logic [gpw_pkg::COLOR_W-1:0] fg,
                           input logic [gpw_pkg::COLOR_W-1:0] bg);
    send_request(gpw_pkg::REQ_DRAW, code, gpw_pkg::GROW_W'($urandom),
                 gpw_pkg::BYTE_W'($urandom), px, py, fg, bg);
  endtask

  task automatic load_glyph(input logic [gpw_pkg::CODE_W-1:0] code);
    int start;
    start = $urandom_range(0, ROWS-1);
    for (int i = 0; i < ROWS; i++)
      load_row(code, gpw_pkg::GROW_W'((start + i) % ROWS), gpw_pkg::BYTE_W'($urandom));
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gpw_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gpw_pkg::REG_FB_BASE:    geo_base   = data;
      gpw_pkg::REG_FB_WIDTH:   geo_width  = data[gpw_pkg::DIM_W-1:0];
      gpw_pkg::REG_FB_HEIGHT:  geo_height = data[gpw_pkg::DIM_W-1:0];
      gpw_pkg::REG_ROW_PITCH:  geo_pitch  = data[gpw_pkg::PITCH_W-1:0];
      gpw_pkg::REG_PIXEL_SIZE: geo_psize  = data[gpw_pkg::PSIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [31:0] base, input int width, input int height,
                              input int pitch, input int psize);
    settle_block();
    write_reg(gpw_pkg::REG_FB_BASE, base);
    write_reg(gpw_pkg::REG_FB_WIDTH, 32'(width));
    write_reg(gpw_pkg::REG_FB_HEIGHT, 32'(height));
    write_reg(gpw_pkg::REG_ROW_PITCH, 32'(pitch));
    write_reg(gpw_pkg::REG_PIXEL_SIZE, 32'(psize));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [gpw_pkg::COORD_W-1:0] pick_coord(input int limit);
    int lo;
    int hi;
    lo = limit - 9;
    hi = limit + 1;
    if (lo < 0) lo = 0;
    if (hi > 4095) hi = 4095;
    if (lo > hi) lo = hi;
    case ($urandom_range(0, 3))
      0, 1: return gpw_pkg::COORD_W'($urandom_range(lo, hi));
      2: return gpw_pkg::COORD_W'($urandom_range(0, 31));
      default: return gpw_pkg::COORD_W'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic random_traffic(input int count);
    int start;
    int sel;
    start = requests_sent;
    while (requests_sent - start < count) begin
      sel = $urandom_range(0, 99);
      if (drawable_codes.size() == 0 || sel < 8) begin
        load_glyph(gpw_pkg::CODE_W'($urandom_range(0, CHARS-1)));
      end else if (sel < 20) begin
        load_row(gpw_pkg::CODE_W'($urandom), gpw_pkg::GROW_W'($urandom),
                 gpw_pkg::BYTE_W'($urandom));
      end else begin
        draw_char(drawable_codes[$urandom_range(0, drawable_codes.size()-1)],
                  pick_coord(int'(geo_width)), pick_coord(int'(geo_height)),
                  $urandom, $urandom);
      end
    end
  endtask

  task automatic test_directed_glyphs();
    logic [gpw_pkg::BYTE_W-1:0] low_rows [ROWS]  =
      '{8'h80, 8'h01, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h3C, 8'hC3};
    logic [gpw_pkg::BYTE_W-1:0] high_rows [ROWS] =
      '{8'h7F, 8'hFE, 8'h0F, 8'hF0, 8'h81, 8'h18, 8'h24, 8'h42};
    for (int r = 0; r < ROWS; r++) load_row(8'h00, gpw_pkg::GROW_W'(r), low_rows[r]);
    for (int r = ROWS-1; r >= 0; r--) load_row(8'hFF, gpw_pkg::GROW_W'(r), high_rows[r]);
    draw_char(8'h00, 12'd0, 12'd0, 32'hFFFF_FFFF, 32'h0000_0000);
    draw_char(8'hFF, 12'hFFF, 12'hFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    draw_char(8'h00, 12'd636, 12'd0, $urandom, $urandom);
    draw_char(8'hFF, 12'd0, 12'd476, $urandom, $urandom);
    draw_char(8'h00, 12'd635, 12'd475, $urandom, $urandom);
    draw_char(8'hFF, 12'd632, 12'd472, $urandom, $urandom);
  endtask

  task automatic test_geometry_extremes();
    set_geometry(32'hFFFF_FFFF, 4096, 4096, 65535, 0);
    random_traffic(30);
    set_geometry(32'h0000_0000, 0, 0, 0, 1);
    random_traffic(20);
    set_geometry($urandom, 13, 9, 100, 2);
    random_traffic(30);
  endtask

  task automatic test_random_geometry();
    repeat (3) begin
      set_geometry($urandom, $urandom_range(0, 4096), $urandom_range(0, 4096),
                   $urandom_range(0, 65535), $urandom_range(0, 3));
      random_traffic(30);
    end
  endtask

  task automatic test_back_to_back();
    set_geometry(32'h8000_0000, 4096, 4096, 16384, 3);
    no_stalls = 1'b1;
    random_traffic(15);
    settle_block();
    random_traffic(15);
    no_stalls = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        flag_mismatch($sformatf("pixel write at %h with nothing pending", pixel_addr));
      end else begin
        want_write = pending_writes.pop_front();
        if (pixel_addr !== want_write.addr)
          flag_mismatch($sformatf("pixel %0d pixel_addr %h, want %h",
                                  pixels_checked, pixel_addr, want_write.addr));
        if (pixel_data !== want_write.color)
          flag_mismatch($sformatf("pixel %0d pixel_data %h, want %h",
                                  pixels_checked, pixel_data, want_write.color));
        if (byte_count !== want_write.nbytes)
          flag_mismatch($sformatf("pixel %0d byte_count %0d, want %0d",
                                  pixels_checked, byte_count, want_write.nbytes));
        if (write_enable !== want_write.we)
          flag_mismatch($sformatf("pixel %0d write_enable %b, want %b",
                                  pixels_checked, write_enable, want_write.we));
        if (pix_last !== want_write.is_last)
          flag_mismatch($sformatf("pixel %0d last %b, want %b",
                                  pixels_checked, pix_last, want_write.is_last));
        pixels_checked++;
        if (!want_write.we) pixels_clipped++;
      end
    end
    out_ready <= no_stalls || ($urandom_range(0, 99) >= STALL_PCT);
  end

  initial begin
    #10_000_000;
    $display("Run timed out with %0d pixel writes pending", pending_writes.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_glyphs();
    test_geometry_extremes();
    test_random_geometry();
    test_back_to_back();
    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_writes.size() != 0)
      flag_mismatch($sformatf("%0d pixel writes never arrived", pending_writes.size()));
    $display("Sent %0d requests: %0d glyph row loads and %0d character draws over %0d geometries",
             requests_sent, loads_sent, draws_sent, settings_used + 1);
    $display("Checked %0d pixel writes, %0d of them clipped; %0d mismatches",
             pixels_checked, pixels_clipped, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/gpw_pkg.sv
hw/rtl/gpw_ram.sv
hw/rtl/gpw_alu.sv
hw/rtl/bitmap_glyph_pixel_writer.sv
dv/bitmap_glyph_pixel_writer_tb.sv
